@@ design/adq_pkg.sv @@
// ----------------------------------------------------------------------------
// adq_pkg
// Shared widths, constants, register indexes and control types of the
// adaptive differential dequantizer.
// ----------------------------------------------------------------------------
package adq_pkg;

	localparam int WINDOW_DEPTH_DEF = 16;

	localparam int CODE_W   = 16;
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;
	localparam int GAIN_W   = 15;
	localparam int WLEN_W   = 5;
	localparam int STEP_W   = 15;
	localparam int SUM_W    = 32;
	localparam int MAG_W    = 16;
	localparam int Q_SHIFT  = 15;
	localparam int BOUND_W  = SUM_W - Q_SHIFT;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COEF = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_WLEN = CFG_IDX_W'(2);

	// reset values
	localparam logic [COEF_W-1:0] COEF_RST = '0;
	localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(16384);
	localparam logic [WLEN_W-1:0] WLEN_RST = WLEN_W'(10);
	localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(1);

	// step search interval and truncation offset for the Q15 product
	localparam logic [STEP_W-1:0] SEARCH_LO = STEP_W'(1);
	localparam logic [STEP_W-1:0] SEARCH_HI = STEP_W'((1 << 15) - 1);
	localparam logic [SUM_W-1:0]  Q15_TRUNC = SUM_W'((1 << Q_SHIFT) - 1);

	typedef struct packed {
		logic load;      // latch code, start window read
		logic mul;       // both products
		logic acc;       // sample, prediction, window update
		logic bound;     // search bound, interval reset
		logic search;    // one bisection step
		logic out_load;  // move sample to output register
	} cmd_t;

	typedef struct packed {
		logic search_done;
	} status_t;

endpackage

@@ design/adq_code_if.sv @@
// ----------------------------------------------------------------------------
// adq_code_if
// Input channel: one quantized code per request.
// ----------------------------------------------------------------------------
interface adq_code_if;
	logic                              valid;
	logic                              ready;
	logic signed [adq_pkg::CODE_W-1:0] code;

	modport source (output valid, output code, input ready);
	modport sink   (input valid, input code, output ready);
endinterface

@@ design/adq_sample_if.sv @@
// ----------------------------------------------------------------------------
// adq_sample_if
// Output channel: one reconstructed sample per request.
// ----------------------------------------------------------------------------
interface adq_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [adq_pkg::SAMPLE_W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

@@ design/adq_ram.sv @@
// ----------------------------------------------------------------------------
// adq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module adq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ design/adq_ctrl.sv @@
// ----------------------------------------------------------------------------
// adq_ctrl
// Sequencer: accept, multiply, accumulate, bound, bisection, output.
// ----------------------------------------------------------------------------
module adq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output adq_pkg::cmd_t    cmd,
	input  adq_pkg::status_t status
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_MUL    = 6'b000010,
		S_ACC    = 6'b000100,
		S_BOUND  = 6'b001000,
		S_SEARCH = 6'b010000,
		S_OUT    = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				cmd.acc = 1'b1;
				state_d = S_BOUND;
			end
			S_BOUND: begin
				cmd.bound = 1'b1;
				state_d   = S_SEARCH;
			end
			S_SEARCH: begin
				cmd.search = 1'b1;
				if (status.search_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				// wait for the output register to drain
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

@@ design/adq_datapath.sv @@
// ----------------------------------------------------------------------------
// adq_datapath
// Configuration registers, reconstruction arithmetic, magnitude window and
// step size bisection.
// ----------------------------------------------------------------------------
module adq_datapath #(
	parameter int WINDOW_DEPTH = adq_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  adq_pkg::cmd_t                       cmd,
	output adq_pkg::status_t                    status,
	input  logic signed [adq_pkg::CODE_W-1:0]   code,
	output logic signed [adq_pkg::SAMPLE_W-1:0] sample_out,
	input  logic                                cfg_we,
	input  logic [adq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [adq_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int POS_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int LEN_W = $clog2(WINDOW_DEPTH + 1);
	localparam int LS_W  = LEN_W + adq_pkg::STEP_W;

	// configuration
	logic [adq_pkg::COEF_W-1:0] coef_q;
	logic [adq_pkg::GAIN_W-1:0] gain_q;
	logic [adq_pkg::WLEN_W-1:0] wlen_q;

	// architectural state
	logic [adq_pkg::STEP_W-1:0]   step_q;
	logic [adq_pkg::SAMPLE_W-1:0] pred_q;
	logic [adq_pkg::SAMPLE_W-1:0] prev_q;
	logic [adq_pkg::SUM_W-1:0]    sum_q;
	logic [POS_W-1:0]             pos_q;
	logic [WINDOW_DEPTH-1:0]      valid_q;

	// per-item working registers
	logic [adq_pkg::CODE_W-1:0]   code_q;
	logic [adq_pkg::SAMPLE_W-1:0] diff_s1;
	logic signed [adq_pkg::SUM_W-1:0] cprod_s1;
	logic [adq_pkg::SAMPLE_W-1:0] out_q;
	logic [adq_pkg::BOUND_W-1:0]  bound_q;
	logic [adq_pkg::STEP_W-1:0]   lo_q;
	logic [adq_pkg::STEP_W-1:0]   hi_q;

	logic [LEN_W-1:0]                            len;
	logic [adq_pkg::CODE_W+adq_pkg::STEP_W-1:0]  dprod;
	logic [adq_pkg::MAG_W-1:0]                   old_mag;
	logic [adq_pkg::MAG_W-1:0]                   ram_rdata;
	logic [adq_pkg::MAG_W-1:0]                   mag;
	logic [adq_pkg::SAMPLE_W-1:0]                sample;
	logic [adq_pkg::SUM_W-1:0]                   qsum;
	logic [adq_pkg::SAMPLE_W-1:0]                q16;
	logic [POS_W:0]                              pos_inc;
	logic [adq_pkg::SUM_W+adq_pkg::GAIN_W-1:0]   bprod;
	logic [adq_pkg::STEP_W:0]                    lohi;
	logic [adq_pkg::STEP_W-1:0]                  mid;
	logic [LS_W-1:0]                             len_mid;
	logic                                        too_big;

	// effective window length: zero reads as one, saturates at the depth
	always_comb begin
		if (wlen_q == '0) begin
			len = LEN_W'(1);
		end else if (32'(wlen_q) > 32'(WINDOW_DEPTH)) begin
			len = LEN_W'(WINDOW_DEPTH);
		end else begin
			len = LEN_W'(wlen_q);
		end
	end

	assign dprod   = code_q * step_q;
	assign old_mag = valid_q[pos_q] ? ram_rdata : '0;
	assign sample  = diff_s1 + pred_q;
	// division by 2^15 truncating toward zero
	assign qsum    = cprod_s1[adq_pkg::SUM_W-1] ? (cprod_s1 + adq_pkg::Q15_TRUNC) : cprod_s1;
	assign q16     = qsum[adq_pkg::Q_SHIFT +: adq_pkg::SAMPLE_W];
	assign mag     = diff_s1[adq_pkg::SAMPLE_W-1] ? (~diff_s1 + 1'b1) : diff_s1;
	assign pos_inc = {1'b0, pos_q} + 1'b1;
	assign bprod   = sum_q * gain_q;

	assign lohi    = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = lohi[adq_pkg::STEP_W:1];
	assign len_mid = len * mid;
	assign too_big = 32'(len_mid) > 32'(bound_q);

	assign status.search_done = cmd.search && (mid == lo_q);

	adq_ram #(
		.WIDTH (adq_pkg::MAG_W),
		.DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (cmd.acc),
		.waddr (pos_q),
		.wdata (mag),
		.re    (cmd.load),
		.raddr (pos_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q  <= adq_pkg::COEF_RST;
			gain_q  <= adq_pkg::GAIN_RST;
			wlen_q  <= adq_pkg::WLEN_RST;
			step_q  <= adq_pkg::STEP_RST;
			pred_q  <= '0;
			prev_q  <= '0;
			sum_q   <= '0;
			pos_q   <= '0;
			valid_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					adq_pkg::REG_COEF: coef_q <= cfg_data[adq_pkg::COEF_W-1:0];
					adq_pkg::REG_GAIN: gain_q <= cfg_data[adq_pkg::GAIN_W-1:0];
					adq_pkg::REG_WLEN: wlen_q <= cfg_data[adq_pkg::WLEN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.acc) begin
				pred_q         <= sample - q16;
				prev_q         <= sample;
				sum_q          <= sum_q - adq_pkg::SUM_W'(old_mag) + adq_pkg::SUM_W'(mag);
				valid_q[pos_q] <= 1'b1;
				if (32'(pos_inc) >= 32'(len)) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_inc[POS_W-1:0];
				end
			end
			if (status.search_done) begin
				step_q <= mid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			code_q <= code;
		end
		if (cmd.mul) begin
			diff_s1  <= dprod[adq_pkg::SAMPLE_W-1:0];
			cprod_s1 <= $signed(coef_q) * $signed(prev_q);
		end
		if (cmd.acc) begin
			out_q <= sample;
		end
		if (cmd.bound) begin
			bound_q <= bprod[adq_pkg::Q_SHIFT +: adq_pkg::BOUND_W];
			lo_q    <= adq_pkg::SEARCH_LO;
			hi_q    <= adq_pkg::SEARCH_HI;
		end else if (cmd.search && !status.search_done) begin
			if (too_big) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid;
			end
		end
	end

	// separate output register so a new item can be worked on while it waits
	logic [adq_pkg::SAMPLE_W-1:0] sample_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sample_q <= out_q;
		end
	end

	assign sample_out = sample_q;

endmodule

@@ design/adaptive_differential_dequantizer.sv @@
// Processing order after a request is accepted: multiply, accumulate,
// bound, step size bisection (one step per cycle), output load. A new
// code is taken while the last result waits in the output register.
// Reset (arst_n, async): step size 1, prediction, sum, position and window
// cleared, registers at their defaults; the window needs no clearing pass.
// ----------------------------------------------------------------------------
// adaptive_differential_dequantizer
// Top level: ADPCM-style sample reconstruction with adaptive step size.
// ----------------------------------------------------------------------------
module adaptive_differential_dequantizer #(
	parameter int WINDOW_DEPTH = adq_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	adq_code_if.sink                       code_ch,
	adq_sample_if.source                   sample_ch,
	input  logic                           cfg_we,
	input  logic [adq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [adq_pkg::CFG_DATA_W-1:0] cfg_data
);

	adq_pkg::cmd_t    cmd;
	adq_pkg::status_t status;

	adq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (code_ch.valid),
		.in_ready  (code_ch.ready),
		.out_valid (sample_ch.valid),
		.out_ready (sample_ch.ready),
		.cmd       (cmd),
		.status    (status)
	);

	adq_datapath #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.code       (code_ch.code),
		.sample_out (sample_ch.sample_out),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

endmodule

@@ bench/tb_adaptive_differential_dequantizer.sv @@
// ----------------------------------------------------------------------------
// tb_adaptive_differential_dequantizer
// Self-checking bench for the dequantizer: codes are sent over the request
// channel with random gaps, and every reconstructed sample is compared with a
// bit-exact software predictor that tracks step size, prediction and the
// magnitude window. Directed cases come first, then random phases over
// several register settings.
// ----------------------------------------------------------------------------
module tb_adaptive_differential_dequantizer;
	timeunit 1ns;
	timeprecision 1ps;

	import adq_pkg::*;

	localparam int HIST_DEPTH   = WINDOW_DEPTH_DEF;
	localparam int DRAIN_CYCLES = 30;
	localparam int PHASE_ITEMS  = 100;
	localparam int PHASES       = 5;

	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	adq_code_if   code_ch ();
	adq_sample_if sample_ch ();

	adaptive_differential_dequantizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.code_ch   (code_ch),
		.sample_ch (sample_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor copy of registers and state
	logic signed [COEF_W-1:0]   coef_q15;
	logic [GAIN_W-1:0]          var_gain;
	logic [WLEN_W-1:0]          win_len;
	logic [STEP_W-1:0]          cur_step;
	logic signed [SAMPLE_W-1:0] cur_pred;
	logic signed [SAMPLE_W-1:0] last_sample;
	logic [SUM_W-1:0]           mag_total;
	logic [MAG_W-1:0]           mag_hist [HIST_DEPTH];
	int                         hist_pos;

	logic signed [SAMPLE_W-1:0] expected_samples [$];
	int                         failures;
	bit                         idle_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end

	function automatic int used_length();
		if (win_len == 0)
			return 1;
		if (win_len > HIST_DEPTH)
			return HIST_DEPTH;
		return int'(win_len);
	endfunction

	// one code in, one sample out; advances the predictor state
	function automatic logic signed [SAMPLE_W-1:0] reconstruct(
		input logic signed [CODE_W-1:0] code
	);
		logic [31:0]                scaled;
		logic signed [SAMPLE_W-1:0] diff;
		logic signed [SAMPLE_W-1:0] sample;
		logic [31:0]                gained;
		logic [31:0]                bound;
		int                         len;
		int                         q;
		int                         mag;
		int unsigned                lo;
		int unsigned                hi;
		int unsigned                s;

		len    = used_length();
		scaled = 32'(code) * 32'(cur_step);
		diff   = scaled[SAMPLE_W-1:0];
		sample = diff + cur_pred;

		q           = (int'(coef_q15) * int'(last_sample)) / 32768;
		cur_pred    = SAMPLE_W'(int'(sample) - q);
		last_sample = sample;

		mag = (diff < 0) ? -int'(diff) : int'(diff);
		if (hist_pos >= HIST_DEPTH)
			hist_pos = 0;
		mag_total          = mag_total - 32'(mag_hist[hist_pos]) + 32'(mag);
		mag_hist[hist_pos] = MAG_W'(mag);

		gained = mag_total * 32'(var_gain);
		bound  = gained >> Q_SHIFT;
		lo = 1;
		hi = 32767;
		s  = (lo + hi) >> 1;
		while (s != lo) begin
			if (32'(len) * s > bound)
				hi = s;
			else
				lo = s;
			s = (lo + hi) >> 1;
		end
		cur_step = STEP_W'(s);

		hist_pos++;
		if (hist_pos >= len)
			hist_pos = 0;
		return sample;
	endfunction

	function automatic int pick_gap();
		int r;

		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(30, 80);
	endfunction

	function automatic logic signed [CODE_W-1:0] random_code();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return CODE_W'(int'($urandom_range(0, 15)) - 8);
			4, 5:       return CODE_W'(int'($urandom_range(0, 511)) - 256);
			6, 7, 8:    return CODE_W'($urandom);
			default: begin
				case ($urandom_range(0, 3))
					0:       return 16'sh8000;
					1:       return 16'sh7fff;
					2:       return '0;
					default: return '1;
				endcase
			end
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_COEF: coef_q15 = data[COEF_W-1:0];
			REG_GAIN: var_gain = data[GAIN_W-1:0];
			REG_WLEN: win_len  = data[WLEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_code(input logic signed [CODE_W-1:0] code);
		int gap;

		gap = pick_gap();
		if (gap > 0) begin
			code_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		code_ch.valid <= 1'b1;
		code_ch.code  <= code;
		do
			@(posedge clk);
		while (!code_ch.ready);
		expected_samples.push_back(reconstruct(code));
	endtask

	// registers change only once the block has gone quiet
	task automatic wait_idle();
		code_ch.valid <= 1'b0;
		while (expected_samples.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_defaults();
		send_code(16'sh8000);   // full-scale negative difference at step 1
		send_code(16'sh7fff);
		send_code('0);
		send_code('1);
		send_code(16'sd1);
		send_code(random_code());
	endtask

	// shrink the window while the position sits past the new length
	task automatic test_window_shrink();
		wait_idle();
		write_reg(REG_WLEN, CFG_DATA_W'(16));
		while (hist_pos < 9)
			send_code(random_code());
		wait_idle();
		write_reg(REG_WLEN, CFG_DATA_W'(4));
		repeat (3) send_code(random_code());
	endtask

	task automatic test_register_extremes();
		wait_idle();
		write_reg(REG_COEF, 16'h8000);
		write_reg(REG_GAIN, CFG_DATA_W'(32767));
		write_reg(REG_WLEN, CFG_DATA_W'(1));
		send_code(16'sh7fff);
		send_code(16'sh8000);
		wait_idle();
		write_reg(REG_COEF, 16'h7fff);
		write_reg(REG_GAIN, '0);
		write_reg(REG_WLEN, '0);
		send_code(16'sh1234);
		send_code(-16'sd77);
		wait_idle();
		write_reg(REG_GAIN, CFG_DATA_W'(32767));
		write_reg(REG_WLEN, CFG_DATA_W'(31));  // saturates to full depth
		send_code(16'sh4000);
		send_code(-16'sd3);
		wait_idle();
		write_reg(REG_UNUSED, 16'hffff);       // must leave everything alone
		send_code(16'sd9);
		send_code(16'sh8001);
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			write_reg(REG_COEF, ($urandom_range(0, 4) == 0)
				? (($urandom_range(0, 1) == 0) ? 16'h8000 : 16'h7fff) : CFG_DATA_W'($urandom));
			write_reg(REG_GAIN, ($urandom_range(0, 4) == 0)
				? (($urandom_range(0, 1) == 0) ? 16'h0000 : 16'h7fff) : CFG_DATA_W'($urandom));
			write_reg(REG_WLEN, CFG_DATA_W'($urandom_range(0, 31)));
			if ($urandom_range(0, 3) == 0)
				write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
			idle_on = (ph != 2);
			repeat (PHASE_ITEMS) send_code(random_code());
		end
		idle_on = 1'b1;
	endtask

	// result side: random back-pressure and comparison against the oldest
	// outstanding prediction
	initial begin
		logic signed [SAMPLE_W-1:0] want;
		int                         stall;

		stall = 0;
		sample_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && sample_ch.valid && sample_ch.ready) begin
				if (expected_samples.size() == 0) begin
					$error("sample_out: unexpected result %0d", sample_ch.sample_out);
					failures++;
				end else begin
					want = expected_samples.pop_front();
					if (sample_ch.sample_out !== want) begin
						$error("sample_out: expected %0d, actual %0d", want,
							sample_ch.sample_out);
						failures++;
					end
				end
			end
			if (stall > 0) begin
				stall--;
				sample_ch.ready <= 1'b0;
			end else begin
				stall = pick_gap();
				sample_ch.ready <= (stall == 0);
				if (stall > 0)
					stall--;
			end
		end
	end

	initial begin
		failures = 0;
		idle_on  = 1'b1;
		coef_q15 = COEF_RST;
		var_gain = GAIN_RST;
		win_len  = WLEN_RST;
		cur_step = STEP_RST;
		cur_pred    = '0;
		last_sample = '0;
		mag_total   = '0;
		hist_pos    = 0;
		foreach (mag_hist[i])
			mag_hist[i] = '0;

		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		code_ch.valid <= 1'b0;
		code_ch.code  <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_window_shrink();
		test_register_extremes();
		test_random_phases();

		wait_idle();
		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
